FILE: hdl/touch_tap_hold_classifier_macros.svh
// Assertion macros for the touch tap/hold classifier.
// Used by the queue and back-end modules; expects clk and rst_n in scope.
`ifndef TOUCH_TAP_HOLD_CLASSIFIER_MACROS_SVH
`define TOUCH_TAP_HOLD_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TTHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tthc_pkg.sv
// Shared types and constants for the touch tap/hold classifier.
// No dependencies; imported by every module of the block.
package tthc_pkg;

    localparam logic [7:0] STATUS_READY_MASK  = 8'h80;
    localparam logic [7:0] STATUS_POINTS_MASK = 8'h0F;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        G_NONE       = 3'd0,
        G_LEFT_TAP   = 3'd1,
        G_RIGHT_TAP  = 3'd2,
        G_LEFT_LONG  = 3'd3,
        G_RIGHT_LONG = 3'd4
    } gesture_t;

    typedef enum logic [2:0] {
        REG_ENABLED       = 3'd0,
        REG_SWAP_XY       = 3'd1,
        REG_INVERT_X      = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_MAX_HOLD_MS   = 3'd4,
        REG_POLL_INTERVAL = 3'd5,
        REG_LONG_PRESS_MS = 3'd6,
        REG_MIN_TAP_MS    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        FRAME_STALE = 2'd0,
        FRAME_UP    = 2'd1,
        FRAME_DOWN  = 2'd2
    } frame_t;

    typedef struct packed {
        logic               enabled;
        logic               swap_xy;
        logic               invert_x;
        logic [14:0]        screen_width;
        logic [31:0]        max_hold_ms;
        logic [31:0]        poll_interval_ms;
        logic [31:0]        long_press_ms;
        logic [31:0]        min_tap_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               status_ok;
        logic [7:0]         status_byte;
        logic               point_ok;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
    } item_t;

    typedef struct packed {
        logic [2:0]         gesture;
        logic               frame_taken;
        logic               contact_held;
    } result_t;

    // decoded frame handed from front end to back end
    typedef struct packed {
        logic [31:0]        now_ms;
        frame_t             frame;
        logic               taken;
        logic [14:0]        px;
    } frame_beat_t;

endpackage

FILE: hdl/tthc_front.sv
// Front end: decodes one sample into stale/up/down plus clamped press X.
// Depends on tthc_pkg.
module tthc_front
    import tthc_pkg::*;
(
    input  cfg_t        cfg,
    input  item_t       item,
    output frame_beat_t beat
);

    logic               ready;
    logic               touching;
    logic signed [15:0] x_sw;
    logic [15:0]        x_inv;
    logic [15:0]        x_fin;
    logic [14:0]        hi;

    assign ready    = item.status_ok && ((item.status_byte & STATUS_READY_MASK) != 8'd0);
    assign touching = (item.status_byte & STATUS_POINTS_MASK) != 8'd0;

    assign x_sw  = cfg.swap_xy ? item.raw_y : item.raw_x;
    // wraps to 16 bits like the controller's signed word
    assign x_inv = {1'b0, cfg.screen_width} - 16'd1 - x_sw;
    assign x_fin = cfg.invert_x ? x_inv : x_sw;
    assign hi    = (cfg.screen_width != 15'd0) ? cfg.screen_width - 15'd1 : 15'd0;

    always_comb
    begin
        beat.now_ms = item.now_ms;
        beat.taken  = ready;
        beat.frame  = FRAME_STALE;
        if (ready)
        begin
            if (!touching)
                beat.frame = FRAME_UP;
            else if (item.point_ok)
                beat.frame = FRAME_DOWN;
        end
        if (x_fin[15])
            beat.px = 15'd0;
        else if (x_fin[14:0] > hi)
            beat.px = hi;
        else
            beat.px = x_fin[14:0];
    end

endmodule

FILE: hdl/tthc_queue.sv
// Short queue between front and back end, registered storage.
// Depends on tthc_pkg and the assertion macro header.
`include "touch_tap_hold_classifier_macros.svh"
module tthc_queue
    import tthc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_beat_t din,
    output logic        full,
    input  logic        pop,
    output frame_beat_t dout,
    output logic        empty
);

    frame_beat_t       mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == Q_CW'(Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    `TTHC_ASSERT_IMP(a_q_bound, 1'b1, count_reg <= Q_CW'(Q_DEPTH), "queue overfilled")
    `TTHC_ASSERT_NEXT(a_q_drain, do_pop && !do_push && (count_reg == Q_CW'(1)), empty, "queue did not drain")

endmodule

FILE: hdl/tthc_back.sv
// Back end: contact state machine over decoded frames, plus result buffer.
// Depends on tthc_pkg and the assertion macro header.
`include "touch_tap_hold_classifier_macros.svh"
module tthc_back
    import tthc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  frame_beat_t beat,
    input  logic        beat_valid,
    output logic        beat_take,
    output result_t     result,
    output logic        empty,
    input  logic        pop
);

    logic              contact_reg, contact_next;
    logic [31:0]       press_time_reg, press_time_next;
    logic [14:0]       press_x_reg, press_x_next;
    logic              long_fired_reg, long_fired_next;
    logic [31:0]       last_poll_reg, last_poll_next;

    result_t           ob_reg [Q_DEPTH];
    logic [Q_AW-1:0]   ob_wr_reg, ob_rd_reg;
    logic [Q_CW-1:0]   ob_count_reg, ob_count_next;
    logic              ob_pop;

    logic [31:0]       age, gap;
    logic              left_half;
    gesture_t          long_code, tap_code, gesture;
    logic              taken;
    result_t           res;

    assign ob_pop    = pop && !empty;
    assign empty     = ob_count_reg == '0;
    assign result    = ob_reg[ob_rd_reg];
    assign beat_take = beat_valid && ((ob_count_reg != Q_CW'(Q_DEPTH)) || ob_pop);

    assign age       = beat.now_ms - press_time_reg;
    assign gap       = beat.now_ms - last_poll_reg;
    assign left_half = press_x_reg < (cfg.screen_width >> 1);
    assign long_code = left_half ? G_LEFT_LONG : G_RIGHT_LONG;
    assign tap_code  = left_half ? G_LEFT_TAP : G_RIGHT_TAP;

    always_comb
    begin
        contact_next    = contact_reg;
        press_time_next = press_time_reg;
        press_x_next    = press_x_reg;
        long_fired_next = long_fired_reg;
        last_poll_next  = last_poll_reg;
        gesture         = G_NONE;
        taken           = 1'b0;
        if (cfg.enabled)
        begin
            if (contact_reg && (age > cfg.max_hold_ms))
            begin
                // hold timeout: silent release
                contact_next    = 1'b0;
                long_fired_next = 1'b0;
            end
            else if (gap < cfg.poll_interval_ms)
            begin
                if (contact_reg && !long_fired_reg && (age >= cfg.long_press_ms))
                begin
                    long_fired_next = 1'b1;
                    gesture         = long_code;
                end
            end
            else
            begin
                last_poll_next = beat.now_ms;
                taken          = beat.taken;
                case (beat.frame)
                    FRAME_DOWN:
                    begin
                        if (!contact_reg)
                        begin
                            contact_next    = 1'b1;
                            press_time_next = beat.now_ms;
                            press_x_next    = beat.px;
                            long_fired_next = 1'b0;
                        end
                        else if (!long_fired_reg && (age >= cfg.long_press_ms))
                        begin
                            long_fired_next = 1'b1;
                            gesture         = long_code;
                        end
                    end
                    FRAME_UP:
                    begin
                        if (contact_reg)
                        begin
                            contact_next = 1'b0;
                            if (!long_fired_reg && (age >= cfg.min_tap_ms))
                                gesture = tap_code;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        res.gesture      = gesture;
        res.frame_taken  = taken;
        res.contact_held = contact_next;
    end

    always_comb
    begin
        ob_count_next = ob_count_reg;
        if (beat_take && !ob_pop)
            ob_count_next = ob_count_reg + 1'b1;
        else if (ob_pop && !beat_take)
            ob_count_next = ob_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_reg    <= 1'b0;
            press_time_reg <= '0;
            press_x_reg    <= '0;
            long_fired_reg <= 1'b0;
            last_poll_reg  <= '0;
            ob_wr_reg      <= '0;
            ob_rd_reg      <= '0;
            ob_count_reg   <= '0;
        end
        else
        begin
            if (beat_take)
            begin
                contact_reg    <= contact_next;
                press_time_reg <= press_time_next;
                press_x_reg    <= press_x_next;
                long_fired_reg <= long_fired_next;
                last_poll_reg  <= last_poll_next;
                ob_wr_reg <= (ob_wr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : ob_wr_reg + 1'b1;
            end
            if (ob_pop)
                ob_rd_reg <= (ob_rd_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : ob_rd_reg + 1'b1;
            ob_count_reg <= ob_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take)
            ob_reg[ob_wr_reg] <= res;
    end

    `TTHC_ASSERT_IMP(a_ob_bound, 1'b1, ob_count_reg <= Q_CW'(Q_DEPTH), "result buffer overfilled")
    `TTHC_ASSERT_NEXT(a_long_sets_flag, beat_take && ((gesture == G_LEFT_LONG) || (gesture == G_RIGHT_LONG)), long_fired_reg, "long press without flag")
    `TTHC_ASSERT_IMP(a_off_quiet, beat_take && !cfg.enabled, (gesture == G_NONE) && !taken, "event while disabled")

endmodule

FILE: hdl/touch_tap_hold_classifier.sv
// A pushed sample is decoded combinationally into the middle queue; the back end applies it
// to the contact state and writes it to the result buffer, poppable from there (empty low).
// Throughput: one sample per cycle; the contact-state update is combinational, so the back
// end drains the middle queue every cycle unless the result side stalls.
// Reset (rst_n low, async): registers return to their defaults, contact state clears,
// both queues empty.
// Top level of the touch tap/hold classifier; depends on tthc_pkg, tthc_front,
// tthc_queue and tthc_back.
module touch_tap_hold_classifier
    import tthc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // sample side
    input  logic        push,
    input  item_t       item,
    output logic        full,
    // result side
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    cfg_t        cfg_reg;
    frame_beat_t front_beat;
    frame_beat_t mid_beat;
    logic        mid_empty;
    logic        mid_take;

    // Configuration registers. The user must write them only while the block is idle (not enforced
    // by the block itself), so the front and back end read them directly with no shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled          <= 1'b0;
            cfg_reg.swap_xy          <= 1'b0;
            cfg_reg.invert_x         <= 1'b0;
            cfg_reg.screen_width     <= 15'd800;
            cfg_reg.max_hold_ms      <= 32'd10000;
            cfg_reg.poll_interval_ms <= 32'd20;
            cfg_reg.long_press_ms    <= 32'd800;
            cfg_reg.min_tap_ms       <= 32'd30;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ENABLED:       cfg_reg.enabled          <= cfg_data[0];
                REG_SWAP_XY:       cfg_reg.swap_xy          <= cfg_data[0];
                REG_INVERT_X:      cfg_reg.invert_x         <= cfg_data[0];
                REG_SCREEN_WIDTH:  cfg_reg.screen_width     <= cfg_data[14:0];
                REG_MAX_HOLD_MS:   cfg_reg.max_hold_ms      <= cfg_data;
                REG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= cfg_data;
                REG_LONG_PRESS_MS: cfg_reg.long_press_ms    <= cfg_data;
                REG_MIN_TAP_MS:    cfg_reg.min_tap_ms       <= cfg_data;
                default:           cfg_reg.enabled          <= cfg_reg.enabled;
            endcase
        end
    end

    // Front end: stateless frame decode, swap/invert and clamp of X.
    tthc_front u_front (
        .cfg  (cfg_reg),
        .item (item),
        .beat (front_beat)
    );

    // Middle queue: a push beat lands here; full backs up the sample side.
    tthc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_beat),
        .full  (full),
        .pop   (mid_take),
        .dout  (mid_beat),
        .empty (mid_empty)
    );

    // Back end: contact/press/long-fired state, poll gating, result buffer.
    tthc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .beat       (mid_beat),
        .beat_valid (!mid_empty),
        .beat_take  (mid_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
